// ----- rtl/core/qbcg_pkg.sv -----
// qbcg_pkg: shared types and constants of the quota batch credit grant block
// no dependencies; imported by every module of the block

package qbcg_pkg;

   localparam int EP_W   = 2;
   localparam int STAMP_W = 32;
   localparam int CAP_W  = 16;

   typedef enum logic [1:0] {
      ST_GRANTED = 2'd0,
      ST_CLOCK   = 2'd1,
      ST_BUDGET  = 2'd2,
      ST_STORAGE = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_DAILY_CAP   = 1'b0,
      CSR_MONTHLY_CAP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [EP_W-1:0]    endpoint;
      logic [STAMP_W-1:0] day_number;
      logic [STAMP_W-1:0] month_number;
      logic               write_ok;
   } req_type;

endpackage

// ----- rtl/core/quota_batch_credit_grant.sv -----
// quota_batch_credit_grant: top level, daily and monthly quota limiter with batched credits
// depends on qbcg_pkg, qbcg_req_reg and qbcg_engine
// the status beat reaches rsp_valid through the input register and then the engine's result register
// throughput: one request per cycle, set by the input register and the single pass decision
// reset: synchronous; clears caps, stamps, usage and credits; busy is high only in reset
// the result strobe lasts one cycle and cannot be held off by the receiver

module quota_batch_credit_grant
   import qbcg_pkg::*;
#(
   parameter int ENDPOINT_COUNT = 3,
   parameter int BATCH_MAX      = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [EP_W-1:0]    req_endpoint,
   input  logic [STAMP_W-1:0] req_day_number,
   input  logic [STAMP_W-1:0] req_month_number,
   input  logic               req_write_ok,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic [0:0]         csr_index,
   input  logic [CAP_W-1:0]   csr_write_data
);

   req_type    req_beat;
   req_type    item;
   logic       item_valid;
   status_type status;

   assign busy = reset;

   always_comb begin
      req_beat.endpoint     = req_endpoint;
      req_beat.day_number   = req_day_number;
      req_beat.month_number = req_month_number;
      req_beat.write_ok     = req_write_ok;
   end

   qbcg_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (start && !busy),
      .req_in     (req_beat),
      .item_valid (item_valid),
      .item       (item)
   );

   qbcg_engine #(
      .ENDPOINT_COUNT (ENDPOINT_COUNT),
      .BATCH_MAX      (BATCH_MAX)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (status)
   );

   assign rsp_status = status;

endmodule

// ----- rtl/core/qbcg_req_reg.sv -----
// qbcg_req_reg: input register that captures one request beat
// depends on qbcg_pkg

module qbcg_req_reg
   import qbcg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  req_type req_in,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   req_type req_next;

   always_comb begin
      valid_in = load;
      req_next = load ? req_in : req_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_next;
   end

   assign item_valid = valid_ff;
   assign item       = req_ff;

endmodule

// ----- rtl/core/qbcg_engine.sv -----
// qbcg_engine: quota state, cap registers, single pass decision and result register
// depends on qbcg_pkg

module qbcg_engine
   import qbcg_pkg::*;
#(
   parameter int ENDPOINT_COUNT = 3,
   parameter int BATCH_MAX      = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  req_type       item,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  logic [CAP_W-1:0] csr_write_data,
   output logic          rsp_valid,
   output status_type    rsp_status
);

   localparam int SUM_W = CAP_W + $clog2(ENDPOINT_COUNT);
   localparam int CRD_W = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
   localparam int N_W   = $clog2(BATCH_MAX + 1);

   logic [CAP_W-1:0]   cap_d_ff, cap_d_in;
   logic [CAP_W-1:0]   cap_m_ff, cap_m_in;
   logic [STAMP_W-1:0] stored_day_ff, stored_day_in;
   logic [STAMP_W-1:0] stored_month_ff, stored_month_in;
   logic [CAP_W-1:0]   day_use_ff [ENDPOINT_COUNT];
   logic [CAP_W-1:0]   day_use_in [ENDPOINT_COUNT];
   logic [CAP_W-1:0]   month_use_ff [ENDPOINT_COUNT];
   logic [CAP_W-1:0]   month_use_in [ENDPOINT_COUNT];
   logic [CRD_W-1:0]   credit_ff [ENDPOINT_COUNT];
   logic [CRD_W-1:0]   credit_in [ENDPOINT_COUNT];
   logic               valid_ff, valid_in;
   status_type         status_ff, status_in;

   logic [ENDPOINT_COUNT-1:0] sel;
   logic [CAP_W-1:0]   wd [ENDPOINT_COUNT];
   logic [CAP_W-1:0]   wm [ENDPOINT_COUNT];
   logic [SUM_W-1:0]   used_d, used_m;
   logic [CRD_W-1:0]   crd_cur;
   logic [CAP_W-1:0]   head_d, head_m, head;
   logic [N_W-1:0]     n;
   logic               clk_err, day_chg, month_chg, any_chg, over, at_cap;

   // decision path
   always_comb begin
      clk_err = (int'(item.endpoint) >= ENDPOINT_COUNT) || (item.day_number == '0)
                || (item.month_number == '0) || (item.day_number < stored_day_ff)
                || (item.month_number < stored_month_ff);
      day_chg   = item.day_number != stored_day_ff;
      month_chg = item.month_number != stored_month_ff;
      any_chg   = day_chg || month_chg;

      used_d  = '0;
      used_m  = '0;
      crd_cur = '0;
      for (int i = 0; i < ENDPOINT_COUNT; i++) begin
         sel[i] = int'(item.endpoint) == i;
         wd[i]  = day_chg ? '0 : day_use_ff[i];
         wm[i]  = month_chg ? '0 : month_use_ff[i];
         used_d = used_d + SUM_W'(wd[i]);
         used_m = used_m + SUM_W'(wm[i]);
         if (sel[i] && !any_chg) begin
            crd_cur = credit_ff[i];
         end
      end

      over   = (used_d > SUM_W'(cap_d_ff)) || (used_m > SUM_W'(cap_m_ff));
      at_cap = (used_d == SUM_W'(cap_d_ff)) || (used_m == SUM_W'(cap_m_ff));

      // only used once both totals are below their caps
      head_d = cap_d_ff - used_d[CAP_W-1:0];
      head_m = cap_m_ff - used_m[CAP_W-1:0];
      head   = (head_m < head_d) ? head_m : head_d;
      n      = (head > CAP_W'(BATCH_MAX)) ? N_W'(BATCH_MAX) : head[N_W-1:0];
   end

   // next state
   always_comb begin
      cap_d_in        = cap_d_ff;
      cap_m_in        = cap_m_ff;
      stored_day_in   = stored_day_ff;
      stored_month_in = stored_month_ff;
      day_use_in      = day_use_ff;
      month_use_in    = month_use_ff;
      credit_in       = credit_ff;
      valid_in        = item_valid;
      status_in       = ST_CLOCK;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DAILY_CAP:   cap_d_in = csr_write_data;
            CSR_MONTHLY_CAP: cap_m_in = csr_write_data;
            default: ;
         endcase
      end

      if (item_valid && !clk_err) begin
         if (any_chg) begin
            for (int i = 0; i < ENDPOINT_COUNT; i++) begin
               credit_in[i] = '0;
            end
         end
         priority if (over) begin
            status_in = ST_BUDGET;
         end else if (crd_cur != '0) begin
            status_in = ST_GRANTED;
            for (int i = 0; i < ENDPOINT_COUNT; i++) begin
               if (sel[i]) begin
                  credit_in[i] = crd_cur - 1'b1;
               end
            end
         end else if (at_cap) begin
            status_in = ST_BUDGET;
         end else if (!item.write_ok) begin
            status_in = ST_STORAGE;
         end else begin
            // commit the batch
            status_in       = ST_GRANTED;
            stored_day_in   = item.day_number;
            stored_month_in = item.month_number;
            for (int i = 0; i < ENDPOINT_COUNT; i++) begin
               day_use_in[i]   = sel[i] ? wd[i] + CAP_W'(n) : wd[i];
               month_use_in[i] = sel[i] ? wm[i] + CAP_W'(n) : wm[i];
               if (sel[i]) begin
                  credit_in[i] = CRD_W'(n - 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_d_ff        <= '0;
         cap_m_ff        <= '0;
         stored_day_ff   <= '0;
         stored_month_ff <= '0;
         for (int i = 0; i < ENDPOINT_COUNT; i++) begin
            day_use_ff[i]   <= '0;
            month_use_ff[i] <= '0;
            credit_ff[i]    <= '0;
         end
         valid_ff <= 1'b0;
      end else begin
         cap_d_ff        <= cap_d_in;
         cap_m_ff        <= cap_m_in;
         stored_day_ff   <= stored_day_in;
         stored_month_ff <= stored_month_in;
         day_use_ff      <= day_use_in;
         month_use_ff    <= month_use_in;
         credit_ff       <= credit_in;
         valid_ff        <= valid_in;
      end
      status_ff <= status_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;

endmodule

// ----- rtl/core/qbcg_checker.sv -----
// qbcg_checker: port level assertions for quota_batch_credit_grant, bound to the top level
// depends on qbcg_pkg

module qbcg_checker
   import qbcg_pkg::*;
#(
   parameter int ENDPOINT_COUNT = 3
)
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [EP_W-1:0]    req_endpoint,
   input logic [STAMP_W-1:0] req_day_number,
   input logic [STAMP_W-1:0] req_month_number,
   input logic               rsp_valid,
   input logic [1:0]         rsp_status
);

   // every request beat gets its status beat, through the input register and the result register
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("request beat without status beat");

   // no status beat without a request beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("status beat without request beat");

   // unknown endpoint is a clock error
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (int'(req_endpoint) >= ENDPOINT_COUNT))
      |-> ##2 (rsp_status == ST_CLOCK))
      else $error("bad endpoint not reported as clock error");

   // zero stamp is a clock error
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_day_number == '0) || (req_month_number == '0)))
      |-> ##2 (rsp_status == ST_CLOCK))
      else $error("zero stamp not reported as clock error");

endmodule

bind quota_batch_credit_grant qbcg_checker #(
   .ENDPOINT_COUNT (ENDPOINT_COUNT)
) u_qbcg_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_endpoint     (req_endpoint),
   .req_day_number   (req_day_number),
   .req_month_number (req_month_number),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status)
);
